// ----- rtl/aes128_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 package
// Shared payload types, register indexes and the round functions of the
// AES-128 block encryption engine.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned Rounds = 10;

  // Register indexes on the configuration port.
  localparam logic RegKeyHigh = 1'b0;
  localparam logic RegKeyLow  = 1'b1;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  // The S-box as a constant table.
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
    8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
    8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
    8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
    8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
    8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
    8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
    8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
    8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
    8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
    8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
    8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
    8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
    8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
    8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
  };

  // Round constants for rounds 1 to 10 (index 0 is round 1).
  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Next round key from the previous one; byte 0 sits in the top bits.
  function automatic logic [127:0] next_key(input logic [127:0] k,
                                            input logic [7:0]   rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows and, unless last, MixColumns. Byte i at [127-8i -: 8].
  function automatic logic [127:0] round_fn(input logic [127:0] s,
                                            input logic         last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      b[i] = SBOX[s[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[4*c+k] = b[4*((c+k)%4)+k];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i];
    end
    round_fn = r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/aes128_block_encrypt_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block encryption engine
// Fully unrolled, pipelined AES-128 encryption with an APB key port.
// ----------------------------------------------------------------------------
// One 128-bit block is taken per cycle unless the output stalls. A block
// passes through one stage for the initial key add and ten round stages,
// each doing one full cipher round together with its key schedule step, so
// the round logic of a stage sets the clock. The whole pipeline advances when
// the output stage is empty or its transfer completes; a stall on the output
// holds every stage. The key sits at address 0x00 (bytes 0 to 7) and 0x08
// (bytes 8 to 15) and is used by each block as it stands when it enters.
module aes128_block_encrypt_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire aes128_pkg::in_item_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output aes128_pkg::out_item_t      out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [63:0]           pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  localparam int unsigned Stages = aes128_pkg::Rounds + 1;

  logic [63:0]  key_high_q, key_low_q;
  logic         adv;
  logic         v   [Stages];
  logic [127:0] st  [Stages];
  logic [127:0] rk  [Stages];
  logic         v0_q;
  logic [127:0] st0_q, rk0_q;

  // Key registers; writes beyond the two registers are dropped.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'b000
                 && paddr[3] == aes128_pkg::RegKeyHigh) begin
      key_high_q <= pwdata;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'b000
                 && paddr[3] == aes128_pkg::RegKeyLow) begin
      key_low_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'b000) begin
      prdata = (paddr[3] == aes128_pkg::RegKeyHigh) ? key_high_q : key_low_q;
    end
  end

  // Global advance: the output stage is free or is being taken.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // First stage: initial round key add.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st0_q <= {in_data_i.plain_high, in_data_i.plain_low}
               ^ {key_high_q, key_low_q};
      rk0_q <= {key_high_q, key_low_q};
    end
  end

  assign v[0]  = v0_q;
  assign st[0] = st0_q;
  assign rk[0] = rk0_q;

  // Ten round stages.
  for (genvar r = 1; r < Stages; r++) begin : g_round
    aes128_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v[r-1]),
      .state_i (st[r-1]),
      .key_i   (rk[r-1]),
      .rcon_i  (aes128_pkg::RCON[r-1]),
      .last_i  (r == Stages - 1),
      .valid_o (v[r]),
      .state_o (st[r]),
      .key_o   (rk[r])
    );
  end

  assign out_valid_o            = v[Stages-1];
  assign out_data_o.cipher_high = st[Stages-1][127:64];
  assign out_data_o.cipher_low  = st[Stages-1][63:0];

endmodule
`default_nettype wire

// ----- rtl/aes128_round.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 round stage
// One pipeline stage: a full cipher round on the state and the key schedule
// step that yields this round's key, carried along with the data.
// ----------------------------------------------------------------------------
module aes128_round (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         valid_i,
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] key_i,
  input  wire logic [7:0]   rcon_i,
  input  wire logic         last_i,
  output logic              valid_o,
  output logic [127:0]      state_o,
  output logic [127:0]      key_o
);

  logic         valid_q;
  logic [127:0] state_q, state_d, key_q, key_d;

  // Round key for this round and the round itself.
  always_comb begin
    key_d   = aes128_pkg::next_key(key_i, rcon_i);
    state_d = aes128_pkg::round_fn(state_i, last_i) ^ key_d;
  end

  // Control bit is reset; the payload only loads when the stage advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule
`default_nettype wire
